[design/sbda_pkg.sv]
// sbda_pkg: constants for the signed binary to decimal ascii converter
// no dependencies
package sbda_pkg;
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;
  localparam logic [3:0] RADIX      = 4'd10;
endpackage

[design/signed_binary_to_decimal_ascii.sv]
// signed binary to decimal ascii: one signed word in, its decimal text out
// pipeline: sign stage, then one double-dabble stage per magnitude bit, then an
// emit stage that walks the bcd digits one character per cycle while stall_i is low.
// an item leaves as 1 to 11 characters at 32 bits, one character per transfer,
// set by the single output port
// reset clears all valid bits and the emit counter; payload registers are not reset
module signed_binary_to_decimal_ascii #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] value_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [6:0]  character_o,
  output logic        last_o
);
  import sbda_pkg::*;

  // digits needed for 2^(WORD_BITS-1): floor(WORD_BITS*log10(2)) + 1 bound
  localparam int NDIG = (WORD_BITS * 1233) / 4096 + 1;
  localparam int BW   = 4 * NDIG;
  localparam int CW   = $clog2(NDIG + 1);
  localparam int NS   = WORD_BITS + 1;

  logic [WORD_BITS-1:0] raw;
  assign raw = WORD_BITS'(value_i);

  // pipeline registers: stage 0 holds magnitude, stage k has shifted k bits
  logic [NS-1:0]        v_q;
  logic [NS-1:0]        neg_q;
  logic [WORD_BITS-1:0] mag_q [NS];
  logic [BW-1:0]        bcd_q [NS];
  logic [NS-1:0]        adv;

  // emit stage
  logic          ev_q;
  logic          eneg_q;
  logic [BW-1:0] ebcd_q;
  logic [CW-1:0] epos_q;
  logic          esign_q;
  logic          done;

  assign done = ev_q && !stall_i && (esign_q == 1'b0) && (epos_q == '0);

  // a stage moves when the one ahead is empty or also moving
  always_comb begin
    adv[NS-1] = !v_q[NS-1] || ((!ev_q || done));
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end
  assign stall_o = !adv[0];

  // double dabble step: add 3 to digits >= 5, then shift in one bit
  function automatic logic [BW-1:0] dabble(input logic [BW-1:0] b, input logic bit_in);
    logic [BW-1:0] t;
    t = b;
    for (int d = 0; d < NDIG; d++) begin
      if (t[4*d +: 4] >= 4'd5) t[4*d +: 4] = t[4*d +: 4] + 4'd3;
    end
    return {t[BW-2:0], bit_in};
  endfunction

  // stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage data
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      neg_q[0] <= raw[WORD_BITS-1];
      mag_q[0] <= raw[WORD_BITS-1] ? (~raw + 1'b1) : raw;
      bcd_q[0] <= '0;
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        neg_q[k] <= neg_q[k-1];
        mag_q[k] <= {mag_q[k-1][WORD_BITS-2:0], 1'b0};
        bcd_q[k] <= dabble(bcd_q[k-1], mag_q[k-1][WORD_BITS-1]);
      end
    end
  end

  // highest nonzero digit of the finished bcd word
  logic [CW-1:0] top;
  always_comb begin
    top = '0;
    for (int d = 1; d < NDIG; d++) begin
      if (bcd_q[NS-1][4*d +: 4] != 4'd0) top = CW'(d);
    end
  end

  // emit one character per transfer, sign first then digits downward
  logic load;
  assign load = v_q[NS-1] && (!ev_q || done);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q    <= 1'b0;
      epos_q  <= '0;
      esign_q <= 1'b0;
    end else if (load) begin
      ev_q    <= 1'b1;
      epos_q  <= top;
      esign_q <= neg_q[NS-1];
    end else if (ev_q && !stall_i) begin
      if (done) ev_q <= 1'b0;
      else if (esign_q) esign_q <= 1'b0;
      else epos_q <= epos_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ebcd_q <= bcd_q[NS-1];
      eneg_q <= neg_q[NS-1];
    end
  end

  logic [3:0] dig;
  assign dig         = ebcd_q[4*epos_q[$clog2(NDIG)-1:0] +: 4];
  assign valid_o     = ev_q;
  assign character_o = esign_q ? CHAR_MINUS : (CHAR_ZERO + {3'd0, dig});
  assign last_o      = !esign_q && (epos_q == '0);

  // assertions
  a_dig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !esign_q |-> dig < RADIX) else $error("bcd digit out of range");
  a_sign_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && esign_q |-> eneg_q) else $error("minus sign on positive value");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(character_o) && $stable(last_o))
    else $error("stalled output changed");
endmodule
